// ----- rtl/md5_message_digest_unit_macros.svh -----
// Assertion helpers for the bind checker file (md5_checker.sv).
`ifndef MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define MD5_MESSAGE_DIGEST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MD5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/md5_pkg.sv -----
`timescale 1ns / 1ps

package md5_pkg;

    // Initial chaining values
    localparam logic [31:0] MD5_H0 = 32'h67452301;
    localparam logic [31:0] MD5_H1 = 32'hefcdab89;
    localparam logic [31:0] MD5_H2 = 32'h98badcfe;
    localparam logic [31:0] MD5_H3 = 32'h10325476;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam int         BLOCK_WORDS = 16;
    localparam int         WORD_BYTES  = 4;
    localparam logic [5:0] ROUND_LAST  = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_LEN,
        ST_OUT
    } md5_state_t;

    // What follows the current compression
    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD1,
        PH_FINAL
    } md5_phase_t;

    typedef struct packed {
        logic       write_byte;
        logic       pad;
        logic       clear_block;
        logic       write_len;
        logic       load_rounds;
        logic       round_step;
        logic       add_chain;
        logic       load_out;
        logic [5:0] round_idx;
    } md5_cmd_t;

    typedef struct packed {
        logic block_full;   // next byte lands in the last slot
        logic pad_two;      // length does not fit after the pad byte
    } md5_stat_t;

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Rotate amount: depends on the quarter and the round within a group of four
    function automatic logic [4:0] md5_s(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    // Message word index; only idx mod 16 matters within a quarter
    function automatic logic [3:0] md5_g(input logic [5:0] idx);
        logic [3:0] g;
        logic [3:0] i4;
        i4 = idx[3:0];
        case (idx[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            2'd3:    g = 4'(i4 * 4'd7);
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] sel, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (sel)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

endpackage

// ----- rtl/md5_ctrl.sv -----
`timescale 1ns / 1ps

module md5_ctrl
    import md5_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      data_valid,
    output logic      data_ready,
    input  logic      last,
    input  logic      no_byte,
    output logic      digest_valid,
    input  logic      digest_ready,
    input  md5_stat_t stat,
    output md5_cmd_t  cmd
);

    md5_state_t state_reg, state_next;
    md5_phase_t phase_reg, phase_next;
    logic       pend_reg, pend_next;       // last seen with the block-filling byte
    logic [5:0] round_reg, round_next;
    logic       outv_reg, outv_next;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DATA;
            pend_reg  <= 1'b0;
            round_reg <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            round_reg <= round_next;
            outv_reg  <= outv_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        round_next = round_reg;
        outv_next  = outv_reg;
        if (outv_reg && digest_ready)
        begin
            outv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (data_valid)
                begin
                    if (!no_byte && stat.block_full)
                    begin
                        pend_next  = last;
                        phase_next = PH_DATA;
                        state_next = ST_LOAD;
                    end
                    else if (last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                phase_next = stat.pad_two ? PH_PAD1 : PH_FINAL;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                case (phase_reg)
                    PH_DATA:
                    begin
                        pend_next  = 1'b0;
                        state_next = pend_reg ? ST_PAD : ST_IDLE;
                    end
                    PH_PAD1:  state_next = ST_LEN;
                    PH_FINAL: state_next = ST_OUT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_LEN:
            begin
                phase_next = PH_FINAL;
                state_next = ST_LOAD;
            end
            ST_OUT:
            begin
                if (!outv_reg || digest_ready)
                begin
                    outv_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd        = '0;
        data_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                data_ready     = 1'b1;
                cmd.write_byte = data_valid && !no_byte;
            end
            ST_PAD:
            begin
                cmd.pad       = 1'b1;
                cmd.write_len = !stat.pad_two;
            end
            ST_LOAD:  cmd.load_rounds = 1'b1;
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                cmd.round_idx  = round_reg;
            end
            ST_ADD:   cmd.add_chain = 1'b1;
            ST_LEN:
            begin
                cmd.clear_block = 1'b1;
                cmd.write_len   = 1'b1;
            end
            ST_OUT:   cmd.load_out = !outv_reg || digest_ready;
            default:  cmd = '0;
        endcase
    end

    assign digest_valid = outv_reg;

endmodule

// ----- rtl/md5_dp.sv -----
`timescale 1ns / 1ps

module md5_dp
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  md5_cmd_t    cmd,
    output md5_stat_t   stat,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);

    logic [31:0] blk_reg   [BLOCK_WORDS];
    logic [31:0] blk_next  [BLOCK_WORDS];
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next[4];
    logic [63:0] count_reg, count_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] kma_reg, kma_next;       // a + K + M, prepared one round ahead
    logic [63:0] dlo_reg, dlo_next;
    logic [63:0] dhi_reg, dhi_next;

    logic [5:0]  pos;
    logic [63:0] len_bits;
    logic [5:0]  idx_nx;
    logic [31:0] f_val;
    logic [31:0] rot_val;
    logic [31:0] kma_round;
    logic [31:0] kma_first;

    assign pos             = count_reg[5:0];
    assign len_bits        = {count_reg[60:0], 3'b000};
    assign stat.block_full = (pos == 6'd63);
    assign stat.pad_two    = (pos[5:3] == 3'b111);

    // Message block: byte insert, padding, clear and length
    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.clear_block)
        begin
            for (int w = 0; w < BLOCK_WORDS; w++)
            begin
                blk_next[w] = '0;
            end
        end
        for (int w = 0; w < BLOCK_WORDS; w++)
        begin
            for (int j = 0; j < WORD_BYTES; j++)
            begin
                if (cmd.write_byte && (6'(w * WORD_BYTES + j) == pos))
                begin
                    blk_next[w][8*j +: 8] = data_byte;
                end
                if (cmd.pad)
                begin
                    if (6'(w * WORD_BYTES + j) == pos)
                    begin
                        blk_next[w][8*j +: 8] = PAD_BYTE;
                    end
                    else if (6'(w * WORD_BYTES + j) > pos)
                    begin
                        blk_next[w][8*j +: 8] = '0;
                    end
                end
            end
        end
        if (cmd.write_len)
        begin
            blk_next[14] = len_bits[31:0];
            blk_next[15] = len_bits[63:32];
        end
    end

    // Round function
    assign idx_nx    = cmd.round_idx + 6'd1;
    assign f_val     = md5_f(cmd.round_idx[5:4], b_reg, c_reg, d_reg);
    assign rot_val   = md5_rotl(kma_reg + f_val, md5_s(cmd.round_idx));
    assign kma_round = d_reg + md5_k(idx_nx) + blk_reg[md5_g(idx_nx)];
    assign kma_first = chain_reg[0] + md5_k(6'd0) + blk_reg[4'd0];

    // Working registers
    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        kma_next = kma_reg;
        if (cmd.load_rounds)
        begin
            a_next   = chain_reg[0];
            b_next   = chain_reg[1];
            c_next   = chain_reg[2];
            d_next   = chain_reg[3];
            kma_next = kma_first;
        end
        else if (cmd.round_step)
        begin
            a_next   = d_reg;
            b_next   = b_reg + rot_val;
            c_next   = b_reg;
            d_next   = c_reg;
            kma_next = kma_round;
        end
    end

    // Chaining words, byte count and digest capture
    always_comb
    begin
        chain_next = chain_reg;
        count_next = count_reg;
        dlo_next   = dlo_reg;
        dhi_next   = dhi_reg;
        if (cmd.write_byte)
        begin
            count_next = count_reg + 64'd1;
        end
        if (cmd.add_chain)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
        end
        if (cmd.load_out)
        begin
            dlo_next      = {chain_reg[1], chain_reg[0]};
            dhi_next      = {chain_reg[3], chain_reg[2]};
            chain_next[0] = MD5_H0;
            chain_next[1] = MD5_H1;
            chain_next[2] = MD5_H2;
            chain_next[3] = MD5_H3;
            count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= MD5_H0;
            chain_reg[1] <= MD5_H1;
            chain_reg[2] <= MD5_H2;
            chain_reg[3] <= MD5_H3;
            count_reg    <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            count_reg <= count_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        kma_reg <= kma_next;
        dlo_reg <= dlo_next;
        dhi_reg <= dhi_next;
    end

    assign digest_low  = dlo_reg;
    assign digest_high = dhi_reg;

endmodule

// ----- rtl/md5_message_digest_unit.sv -----
// Byte items are taken while idle; the 64th byte of a block starts a compression
// (load, 64 rounds, chain add) during which data_ready is low. After the last item
// come a pad step and a compression, and a length step and another compression
// if the length needs a second block, then the digest load (digest_valid).
// Reset (async, rst_n low) restores the initial chaining words, zeroes the byte
// count and drops any pending digest; the block buffer is not cleared.
`timescale 1ns / 1ps

module md5_message_digest_unit
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic        no_byte,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);

    md5_cmd_t  cmd;
    md5_stat_t stat;

    md5_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .last         (last),
        .no_byte      (no_byte),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    md5_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_low  (digest_low),
        .digest_high (digest_high)
    );

endmodule

// ----- rtl/md5_checker.sv -----
`timescale 1ns / 1ps
`include "md5_message_digest_unit_macros.svh"

module md5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        data_valid,
    input logic        data_ready,
    input logic [7:0]  data_byte,
    input logic        last,
    input logic        no_byte,
    input logic        digest_valid,
    input logic        digest_ready,
    input logic [63:0] digest_low,
    input logic [63:0] digest_high
);

    // A waiting digest holds until its transfer
    `MD5_ASSERT_NEXT(a_digest_hold, digest_valid && !digest_ready,
        digest_valid && $stable(digest_low) && $stable(digest_high),
        "digest changed while stalled")

    // Ending a message starts padding or a compression, so intake stops
    `MD5_ASSERT_NEXT(a_last_stalls, data_valid && data_ready && last, !data_ready,
        "intake still open after last item")

    // An empty non-last item changes nothing
    `MD5_ASSERT_NEXT(a_empty_noop, data_valid && data_ready && no_byte && !last, data_ready,
        "empty item stalled intake")

    // A last transfer that carries a byte carries a known value
    `MD5_ASSERT_NOW(a_ready_known, data_valid && data_ready && last,
        !$isunknown(data_byte) || no_byte, "unknown byte on last item")

endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (.*);

// ----- sim/md5_digest_checker.sv -----
`timescale 1ns / 1ps

module md5_digest_checker
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic        no_byte,
    input  logic        digest_valid,
    input  logic        digest_ready,
    input  logic [63:0] digest_low,
    input  logic [63:0] digest_high,
    output int          fail_count,
    output int          pending_count,
    output int          digests_checked
);

    // Sine-derived additive constants, round 0 in the top word
    localparam logic [64*32-1:0] ADD_CONST = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts: four per quarter, repeating every four rounds
    localparam logic [16*5-1:0] ROT_BY = {
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
    } digest_t;

    logic [31:0] msg_words [16];
    logic [31:0] chain [4];
    logic [63:0] bytes_taken;
    digest_t     expected_digests [$];
    int          mismatches;
    int          checked;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
        if (n == 0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic start_new_message();
        chain[0]    = MD5_H0;
        chain[1]    = MD5_H1;
        chain[2]    = MD5_H2;
        chain[3]    = MD5_H3;
        bytes_taken = '0;
    endtask

    task automatic put_byte_at(input int unsigned pos, input logic [7:0] value);
        msg_words[(pos >> 2) & 15][(pos & 3) * 8 +: 8] = value;
    endtask

    // 64 rounds over the current block, then fold into the chaining words
    task automatic compress_block();
        logic [31:0] a, b, c, d, f, sum;
        int unsigned g, q;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++) begin
            q = i / 16;
            case (q)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) & 15;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) & 15;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) & 15;
                end
            endcase
            sum = a + f + ADD_CONST[(63 - i) * 32 +: 32] + msg_words[g];
            a = d;
            d = c;
            c = b;
            b = b + rotate_left(sum, 32'(ROT_BY[(15 - (q * 4 + (i % 4))) * 5 +: 5]));
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endtask

    // One accepted input transfer; a final item queues the expected digest
    task automatic absorb_item(input logic [7:0] value, input logic is_last, input logic empty);
        int unsigned pos;
        logic [63:0] bit_len;
        if (!empty)
        begin
            pos = 32'(bytes_taken[5:0]);
            put_byte_at(pos, value);
            bytes_taken = bytes_taken + 1;
            if (pos == 63)
                compress_block();
        end
        if (is_last)
        begin
            pos = 32'(bytes_taken[5:0]);
            put_byte_at(pos, PAD_BYTE);
            for (int unsigned i = pos + 1; i < 64; i++)
                put_byte_at(i, 8'h00);
            // no room left for the length: it goes into an extra block
            if (pos >= 56)
            begin
                compress_block();
                for (int i = 0; i < 16; i++)
                    msg_words[i] = '0;
            end
            bit_len       = bytes_taken << 3;
            msg_words[14] = bit_len[31:0];
            msg_words[15] = bit_len[63:32];
            compress_block();
            expected_digests.push_back('{low:  {chain[1], chain[0]},
                                         high: {chain[3], chain[2]}});
            start_new_message();
        end
    endtask

    // Outputs are compared before the same-edge input is absorbed
    always @(posedge clk or negedge rst_n)
    begin
        digest_t want;
        if (!rst_n)
        begin
            start_new_message();
            for (int i = 0; i < 16; i++)
                msg_words[i] = '0;
            expected_digests.delete();
        end
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (expected_digests.size() == 0)
                begin
                    $error("digest with no message pending: low %h high %h",
                           digest_low, digest_high);
                    mismatches++;
                end
                else
                begin
                    want = expected_digests.pop_front();
                    if (digest_low !== want.low)
                    begin
                        $error("digest_low: expected %h, got %h", want.low, digest_low);
                        mismatches++;
                    end
                    if (digest_high !== want.high)
                    begin
                        $error("digest_high: expected %h, got %h", want.high, digest_high);
                        mismatches++;
                    end
                    checked++;
                end
            end
            if (data_valid && data_ready)
                absorb_item(data_byte, last, no_byte);
        end
        fail_count      <= mismatches;
        pending_count   <= expected_digests.size();
        digests_checked <= checked;
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET    = 400;
    localparam int MESSAGE_TARGET = 24;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        data_valid   = 1'b0;
    logic        data_ready;
    logic [7:0]  data_byte    = 8'h00;
    logic        last         = 1'b0;
    logic        no_byte      = 1'b0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    int fail_count;
    int pending_count;
    int digests_checked;

    int items_sent;
    int messages_sent;
    int gap_mode;
    int quiet_cycles;
    bit quiet_tail;
    bit long_hold_req;
    bit hold_done;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    md5_message_digest_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .last         (last),
        .no_byte      (no_byte),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_low   (digest_low),
        .digest_high  (digest_high)
    );

    md5_digest_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_valid      (data_valid),
        .data_ready      (data_ready),
        .data_byte       (data_byte),
        .last            (last),
        .no_byte         (no_byte),
        .digest_valid    (digest_valid),
        .digest_ready    (digest_ready),
        .digest_low      (digest_low),
        .digest_high     (digest_high),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .digests_checked (digests_checked)
    );

    // One input transfer, optionally preceded by an idle burst
    task automatic send_item(input logic [7:0] value, input logic is_last, input logic empty);
        if (!quiet_tail && gap_mode != 0 &&
            $urandom_range(0, (gap_mode == 1) ? 5 : 1) == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= value;
        last       <= is_last;
        no_byte    <= empty;
        do
            @(posedge clk);
        while (!data_ready);
        if (!(empty && !is_last))
            items_sent++;
    endtask

    // Message of len bytes, with stray empty items mixed in
    task automatic send_message(input int unsigned len);
        bit tail_apart;
        tail_apart = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int unsigned n = 0; n < len; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b1);
            send_item(8'($urandom), !tail_apart && (n == len - 1), 1'b0);
        end
        if (tail_apart)
            send_item(8'($urandom), 1'b1, 1'b1);
        messages_sent++;
    endtask

    // Stop offering and wait for every outstanding digest
    task automatic wait_drained();
        data_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned pick_length();
        int unsigned pad_edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 14)
            return $urandom_range(0, 12);
        if (roll < 17)
            return pad_edges[$urandom_range(0, 9)];
        return $urandom_range(13, 70);
    endfunction

    // Digest receiver: random stalls, one long hold on request
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !hold_done)
            begin
                digest_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                digest_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                digest_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (data_valid && data_ready) || (digest_valid && digest_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, single-byte extremes, stray empty items, "abc"
        gap_mode = 0;
        send_item(8'h3c, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h61, 1'b0, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h62, 1'b0, 1'b0);
        send_item(8'h63, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        messages_sent = 5;

        // long output hold while short messages keep coming
        long_hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_message($urandom_range(1, 3));
        wait_drained();

        // random messages, tail part without idling
        while (items_sent < ITEM_TARGET || messages_sent < MESSAGE_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - 60 && messages_sent >= MESSAGE_TARGET - 5)
                quiet_tail = 1'b1;
            gap_mode = quiet_tail ? 0 : $urandom_range(0, 2);
            send_message(pick_length());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d message bytes and final items in %0d messages, %0d digests compared,",
                 items_sent, messages_sent, digests_checked);
        $display("including pad-boundary lengths, empty tails, stray empty items and a long output hold.");
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_ctrl.sv
rtl/md5_dp.sv
rtl/md5_message_digest_unit.sv
rtl/md5_checker.sv
sim/md5_digest_checker.sv
sim/tb.sv
